FILE: hw/rtl/msgpt_pkg.sv
// Shared types, codes and defaults of the multi-slot pulse timer.
package msgpt_pkg;

  localparam int SLOT_COUNT_DEF = 4;
  localparam int TIME_BITS_DEF  = 32;
  localparam int MAX_RESULTS    = 4;

  localparam logic [2:0] CMD_INIT    = 3'd0;
  localparam logic [2:0] CMD_TRIGGER = 3'd1;
  localparam logic [2:0] CMD_CANCEL  = 3'd2;
  localparam logic [2:0] CMD_TICK    = 3'd3;
  localparam logic [2:0] CMD_QUERY   = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_ZERO   = 2'd1;
  localparam logic [1:0] ST_NOFREE = 2'd2;

  typedef enum logic [3:0] {
    UOP_IDLE,
    UOP_LOAD,
    UOP_INIT,
    UOP_TCHK,
    UOP_TSEL,
    UOP_FIND,
    UOP_TWR,
    UOP_CANC,
    UOP_QRY,
    UOP_TBEG,
    UOP_DEC,
    UOP_PICK,
    UOP_SOON,
    UOP_EMIT
  } uop_t;

  typedef struct packed {
    uop_t op;
    logic first;
    logic last;
  } ctl_t;

  typedef struct packed {
    logic reject;
    logic pool;
    logic nofree;
    logic more;
    logic emit_last;
  } flags_t;

endpackage

FILE: hw/rtl/multi_slot_gpio_pulse_timer.sv
// Top level of the multi-slot pulse timer: sequencer plus datapath.
// A pool trigger first searches the slot file for a free slot; a tick decrements every
// scheduled slot, then runs 1 to 4 expiry scan passes of the slot file; every command ends
// with a scan of the slot file for the soonest remaining time before its beats.
// Beats follow one per cycle; busy drops as the final beat shows on the ports.
// Synchronous reset frees all slots, clears the tick base; ready next cycle.
module multi_slot_gpio_pulse_timer
  import msgpt_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command,
  input  logic [1:0]  slot,
  input  logic        use_named_slot,
  input  logic [7:0]  pin,
  input  logic        level,
  input  logic [31:0] pulse_ms,
  input  logic [31:0] now_ms,
  input  logic        restore_on_cancel,
  output logic        strobe,
  output logic [1:0]  status,
  output logic [1:0]  result_slot,
  output logic        pin_write,
  output logic [7:0]  write_pin,
  output logic        write_level,
  output logic        active,
  output logic [31:0] soonest_remaining_ms,
  output logic        any_expired,
  output logic        last
);

  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  ctl_t          ctl;
  flags_t        flags;
  logic [SW-1:0] idx;

  msgpt_useq #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_useq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .command(command),
    .flags  (flags),
    .busy   (busy),
    .ctl    (ctl),
    .idx    (idx)
  );

  msgpt_dpath #(
    .SLOT_COUNT(SLOT_COUNT),
    .TIME_BITS (TIME_BITS)
  ) u_dpath (
    .clk                 (clk),
    .rst                 (rst),
    .ctl                 (ctl),
    .idx                 (idx),
    .command             (command),
    .slot                (slot),
    .use_named_slot      (use_named_slot),
    .pin                 (pin),
    .level               (level),
    .pulse_ms            (pulse_ms),
    .now_ms              (now_ms),
    .restore_on_cancel   (restore_on_cancel),
    .flags               (flags),
    .strobe              (strobe),
    .status              (status),
    .result_slot         (result_slot),
    .pin_write           (pin_write),
    .write_pin           (write_pin),
    .write_level         (write_level),
    .active              (active),
    .soonest_remaining_ms(soonest_remaining_ms),
    .any_expired         (any_expired),
    .last                (last)
  );

  a_beat_from_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("beat without a command in progress");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted command did not start the sequencer");

  a_beats_contiguous: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |=> strobe)
    else $error("gap inside the beats of one command");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |=> !strobe)
    else $error("beat right after the final beat");

endmodule

FILE: hw/rtl/msgpt_useq.sv
// Microcode sequencer: step counter, control ROM, slot scan counter.
module msgpt_useq
  import msgpt_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [2:0]    command,
  input  flags_t        flags,
  output logic          busy,
  output ctl_t          ctl,
  output logic [SW-1:0] idx
);

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_TCHK, S_TSEL, S_FIND, S_TWR, S_CANC,
    S_QRY, S_TBEG, S_DEC, S_PICK, S_SOON, S_EMIT
  } step_t;

  typedef enum logic [1:0] {LP_NONE, LP_SLOTS, LP_RESULTS} loop_t;
  typedef enum logic [2:0] {C_NONE, C_REJECT, C_POOL, C_NOFREE, C_MORE} cond_t;

  typedef struct packed {
    uop_t  op;
    loop_t lp;
    cond_t cnd;
    step_t nxt;
    step_t alt;
  } cword_t;

  localparam logic [SW-1:0] IDX_LAST = SW'(SLOT_COUNT - 1);

  function automatic cword_t urom(step_t s);
    cword_t w;
    case (s)
      S_INIT:  w = '{UOP_INIT, LP_NONE,    C_NONE,   S_SOON, S_SOON};
      S_TCHK:  w = '{UOP_TCHK, LP_NONE,    C_REJECT, S_TSEL, S_SOON};
      S_TSEL:  w = '{UOP_TSEL, LP_NONE,    C_POOL,   S_TWR,  S_FIND};
      S_FIND:  w = '{UOP_FIND, LP_SLOTS,   C_NOFREE, S_TWR,  S_SOON};
      S_TWR:   w = '{UOP_TWR,  LP_NONE,    C_NONE,   S_SOON, S_SOON};
      S_CANC:  w = '{UOP_CANC, LP_NONE,    C_NONE,   S_SOON, S_SOON};
      S_QRY:   w = '{UOP_QRY,  LP_NONE,    C_NONE,   S_SOON, S_SOON};
      S_TBEG:  w = '{UOP_TBEG, LP_NONE,    C_NONE,   S_DEC,  S_DEC};
      S_DEC:   w = '{UOP_DEC,  LP_SLOTS,   C_NONE,   S_PICK, S_PICK};
      S_PICK:  w = '{UOP_PICK, LP_SLOTS,   C_MORE,   S_SOON, S_PICK};
      S_SOON:  w = '{UOP_SOON, LP_SLOTS,   C_NONE,   S_EMIT, S_EMIT};
      S_EMIT:  w = '{UOP_EMIT, LP_RESULTS, C_NONE,   S_IDLE, S_IDLE};
      default: w = '{UOP_IDLE, LP_NONE,    C_NONE,   S_IDLE, S_IDLE};
    endcase
    return w;
  endfunction

  function automatic step_t entry(logic [2:0] c);
    step_t s;
    case (c)
      CMD_INIT:    s = S_INIT;
      CMD_TRIGGER: s = S_TCHK;
      CMD_CANCEL:  s = S_CANC;
      CMD_TICK:    s = S_TBEG;
      CMD_QUERY:   s = S_QRY;
      default:     s = S_SOON;
    endcase
    return s;
  endfunction

  step_t         step, step_next;
  logic [SW-1:0] idx_next;
  cword_t        cw;
  logic          loop_end;
  logic          cond_hit;

  assign busy = (step != S_IDLE);

  always_comb begin
    cw = urom(step);
    case (cw.lp)
      LP_SLOTS:   loop_end = (idx == IDX_LAST);
      LP_RESULTS: loop_end = flags.emit_last;
      default:    loop_end = 1'b1;
    endcase
    case (cw.cnd)
      C_REJECT: cond_hit = flags.reject;
      C_POOL:   cond_hit = flags.pool;
      C_NOFREE: cond_hit = flags.nofree;
      C_MORE:   cond_hit = flags.more;
      default:  cond_hit = 1'b0;
    endcase
    if (step == S_IDLE) begin
      step_next = start ? entry(command) : S_IDLE;
    end else if (!loop_end) begin
      step_next = step;
    end else begin
      step_next = cond_hit ? cw.alt : cw.nxt;
    end
    if (cw.lp == LP_SLOTS && !loop_end) begin
      idx_next = idx + SW'(1);
    end else begin
      idx_next = '0;
    end
    ctl.op    = (step == S_IDLE) ? (start ? UOP_LOAD : UOP_IDLE) : cw.op;
    ctl.first = (idx == '0);
    ctl.last  = (idx == IDX_LAST);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= S_IDLE;
      idx  <= '0;
    end else begin
      step <= step_next;
      idx  <= idx_next;
    end
  end

endmodule

FILE: hw/rtl/msgpt_dpath.sv
// Datapath: slot state, scan registers, result buffer and output register.
module msgpt_dpath
  import msgpt_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF,
  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  ctl_t          ctl,
  input  logic [SW-1:0] idx,
  input  logic [2:0]    command,
  input  logic [1:0]    slot,
  input  logic          use_named_slot,
  input  logic [7:0]    pin,
  input  logic          level,
  input  logic [31:0]   pulse_ms,
  input  logic [31:0]   now_ms,
  input  logic          restore_on_cancel,
  output flags_t        flags,
  output logic          strobe,
  output logic [1:0]    status,
  output logic [1:0]    result_slot,
  output logic          pin_write,
  output logic [7:0]    write_pin,
  output logic          write_level,
  output logic          active,
  output logic [31:0]   soonest_remaining_ms,
  output logic          any_expired,
  output logic          last
);

  localparam int TB = TIME_BITS;
  localparam int RW = $clog2(MAX_RESULTS);
  localparam int NW = $clog2(MAX_RESULTS + 1);

  logic [TB-1:0]         rem     [SLOT_COUNT];
  logic [TB-1:0]         rem_pre [SLOT_COUNT];
  logic [7:0]            spin    [SLOT_COUNT];
  logic                  slvl    [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] sched;
  logic [SLOT_COUNT-1:0] pool;

  logic [2:0]    cmd_q;
  logic [1:0]    slot_q;
  logic          named_q;
  logic [7:0]    pin_q;
  logic          lvl_q;
  logic [TB-1:0] dur_q;
  logic [TB-1:0] now_q;
  logic          rest_q;

  logic [TB-1:0] last_tick;
  logic [TB-1:0] elapsed;
  logic [SW-1:0] sel;
  logic          found;
  logic [SW-1:0] pbest_idx;
  logic [TB-1:0] pbest;
  logic          pfound;
  logic [31:0]   soon;
  logic [SW-1:0] pick_q [MAX_RESULTS];
  logic [NW-1:0] n;
  logic [RW-1:0] kidx;

  logic [1:0] res_status;
  logic [1:0] res_slot;
  logic       res_wr;
  logic [7:0] res_pin;
  logic       res_lvl;
  logic       res_active;

  logic [SW-1:0] si;
  logic          in_range;
  logic [TB-1:0] rem_i;
  logic          sched_i;
  logic          free_i;
  logic [TB-1:0] rem_dec;
  logic          cand;
  logic          pfound_eff;
  logic          better;
  logic [SW-1:0] win_idx;
  logic          win_found;
  logic [31:0]   soon_eff;
  logic [31:0]   soon_i;
  logic [31:0]   soon_upd;
  logic [SW-1:0] rd_addr;
  logic [7:0]    rd_pin;
  logic          rd_lvl;
  logic          tick_emit;

  always_comb begin
    si         = SW'(slot_q);
    in_range   = (int'(slot_q) < SLOT_COUNT);
    rem_i      = rem[idx];
    sched_i    = sched[idx];
    free_i     = !sched[idx] && !pool[idx];
    rem_dec    = (rem_i > elapsed) ? (rem_i - elapsed) : '0;
    cand       = sched_i && (rem_i == '0);
    pfound_eff = pfound && !ctl.first;
    better     = cand && (!pfound_eff || (rem_pre[idx] < pbest));
    win_idx    = better ? idx : pbest_idx;
    win_found  = better || pfound_eff;
    soon_eff   = ctl.first ? '1 : soon;
    soon_i     = 32'(rem_i);
    soon_upd   = (sched_i && (soon_i < soon_eff)) ? soon_i : soon_eff;
    rd_addr    = (ctl.op == UOP_CANC) ? si : pick_q[kidx];
    rd_pin     = spin[rd_addr];
    rd_lvl     = slvl[rd_addr];
    tick_emit  = (cmd_q == CMD_TICK) && (n != '0);

    flags.reject    = (dur_q == '0) || (named_q && !in_range);
    flags.pool      = !named_q;
    flags.nofree    = !found && !free_i;
    flags.more      = win_found && (n < NW'(MAX_RESULTS - 1));
    flags.emit_last = tick_emit ? (NW'(kidx) == (n - NW'(1))) : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sched     <= '0;
      pool      <= '0;
      last_tick <= '0;
      strobe    <= 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        rem[i] <= '0;
      end
    end else begin
      strobe <= 1'b0;
      case (ctl.op)
        UOP_LOAD: begin
          cmd_q      <= command;
          slot_q     <= slot;
          named_q    <= use_named_slot;
          pin_q      <= pin;
          lvl_q      <= level;
          dur_q      <= pulse_ms[TB-1:0];
          now_q      <= now_ms[TB-1:0];
          rest_q     <= restore_on_cancel;
          res_status <= ST_OK;
          res_slot   <= '0;
          res_wr     <= 1'b0;
          res_pin    <= '0;
          res_lvl    <= 1'b0;
          res_active <= 1'b0;
          found      <= 1'b0;
          n          <= '0;
          kidx       <= '0;
        end
        UOP_INIT: begin
          last_tick <= now_q;
        end
        UOP_TCHK: begin
          if (dur_q == '0) begin
            res_status <= ST_ZERO;
          end else if (named_q && !in_range) begin
            res_status <= ST_NOFREE;
          end
        end
        UOP_TSEL: begin
          sel <= si;
        end
        UOP_FIND: begin
          if (!found && free_i) begin
            found <= 1'b1;
            sel   <= idx;
          end
          if (ctl.last && !found && !free_i) begin
            res_status <= ST_NOFREE;
          end
        end
        UOP_TWR: begin
          sched[sel] <= 1'b1;
          pool[sel]  <= !named_q;
          spin[sel]  <= pin_q;
          slvl[sel]  <= !lvl_q;
          rem[sel]   <= dur_q;
          res_slot   <= 2'(sel);
          res_wr     <= 1'b1;
          res_pin    <= pin_q;
          res_lvl    <= lvl_q;
        end
        UOP_CANC: begin
          res_slot <= slot_q;
          if (in_range) begin
            sched[si] <= 1'b0;
            pool[si]  <= 1'b0;
            rem[si]   <= '0;
            if (rest_q) begin
              res_wr  <= 1'b1;
              res_pin <= rd_pin;
              res_lvl <= rd_lvl;
            end
          end
        end
        UOP_QRY: begin
          res_slot   <= slot_q;
          res_active <= in_range && sched[si];
        end
        UOP_TBEG: begin
          elapsed   <= now_q - last_tick;
          last_tick <= now_q;
        end
        UOP_DEC: begin
          rem_pre[idx] <= rem_i;
          if (sched_i) begin
            rem[idx] <= rem_dec;
          end
        end
        UOP_PICK: begin
          pfound    <= win_found;
          pbest_idx <= win_idx;
          if (better) begin
            pbest <= rem_pre[idx];
          end
          if (ctl.last && win_found) begin
            pick_q[n[RW-1:0]] <= win_idx;
            sched[win_idx]    <= 1'b0;
            pool[win_idx]     <= 1'b0;
            n                 <= n + NW'(1);
          end
        end
        UOP_SOON: begin
          soon <= soon_upd;
        end
        UOP_EMIT: begin
          strobe               <= 1'b1;
          last                 <= flags.emit_last;
          soonest_remaining_ms <= soon;
          kidx                 <= kidx + RW'(1);
          if (tick_emit) begin
            status      <= ST_OK;
            result_slot <= 2'(pick_q[kidx]);
            pin_write   <= 1'b1;
            write_pin   <= rd_pin;
            write_level <= rd_lvl;
            active      <= 1'b0;
            any_expired <= 1'b1;
          end else begin
            status      <= res_status;
            result_slot <= res_slot;
            pin_write   <= res_wr;
            write_pin   <= res_pin;
            write_level <= res_lvl;
            active      <= res_active;
            any_expired <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
